### design/tfir_pkg.sv
package tfir_pkg;

    localparam int MAX_ORDER_DEF   = 6;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS       = 16;
    localparam int COEF_FRAC       = 15;
    localparam int ACC_BITS        = 40;
    localparam int ORDER_BITS      = 3;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_ORDER = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_BASE    = 3'd1;

    typedef struct packed {
        logic load;
        logic update;
        logic active;
        logic tail;
    } cell_ctrl_t;

endpackage

### design/tfir_cell.sv
module tfir_cell #(
    parameter int SAMPLE_BITS = tfir_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tfir_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [tfir_pkg::COEF_BITS-1:0] coef,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic signed [tfir_pkg::ACC_BITS-1:0] sum_in,
    output logic signed [tfir_pkg::ACC_BITS-1:0] sum_out
);

    localparam int PROD_W = SAMPLE_BITS + tfir_pkg::COEF_BITS;
    localparam int AW     = tfir_pkg::ACC_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [AW-1:0]     sum_reg;
    logic signed [AW-1:0]     sum_next;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            prod_reg <= coef * sample;
        end
    end

    always_comb begin
        if (ctrl.active) begin
            sum_next = AW'(prod_reg) + (ctrl.tail ? sum_in : '0);
        end else begin
            sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.update) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

### design/tfir_out.sv
module tfir_out #(
    parameter int SAMPLE_BITS = tfir_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tfir_pkg::ACC_BITS-1:0] acc,
    input  logic                                 frame_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_sample_out,
    output logic                                 m_clipped,
    output logic                                 m_frame_end_out
);

    localparam int AW = tfir_pkg::ACC_BITS;
    localparam int FR = tfir_pkg::COEF_FRAC;
    localparam int RW = AW + 1 - FR;
    localparam logic signed [RW-1:0] MAXV = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] MINV = RW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          clip_reg;
    logic                          frame_reg;
    logic signed [AW:0]            biased;
    logic signed [RW-1:0]          rounded;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic                          clip_next;

    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        biased  = (AW+1)'(acc) + (AW+1)'(64'sd1 <<< (FR - 1));
        rounded = RW'(biased >>> FR);
        if (rounded > MAXV) begin
            sample_next = SAMPLE_BITS'(MAXV);
            clip_next   = 1'b1;
        end else if (rounded < MINV) begin
            sample_next = SAMPLE_BITS'(MINV);
            clip_next   = 1'b1;
        end else begin
            sample_next = rounded[SAMPLE_BITS-1:0];
            clip_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sample_reg <= sample_next;
            clip_reg   <= clip_next;
            frame_reg  <= frame_end;
        end
    end

    assign m_valid         = valid_reg;
    assign m_sample_out    = sample_reg;
    assign m_clipped       = clip_reg;
    assign m_frame_end_out = frame_reg;

endmodule

### design/transposed_fir_filter_top.sv
// An input beat reaches m_* through the product register, the accumulate/partial-sum
// update register and the round/saturate output register.
// Throughput: one beat per cycle unless m_ready stalls; sums move only with a beat.
// Backpressure compresses bubbles stage by stage; cfg_ready is always high.
// Reset (aresetn low, synchronous) clears partial sums, coefficients, order, valids.
module transposed_fir_filter_top #(
    parameter int MAX_ORDER   = tfir_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_BITS = tfir_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [tfir_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [tfir_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [SAMPLE_BITS-1:0]             s_sample_in,
    input  logic                                      s_frame_end_in,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [SAMPLE_BITS-1:0]             m_sample_out,
    output logic                                      m_clipped,
    output logic                                      m_frame_end_out
);

    localparam int AW     = tfir_pkg::ACC_BITS;
    localparam int CW     = tfir_pkg::COEF_BITS;
    localparam int OW     = tfir_pkg::ORDER_BITS;
    localparam int IW     = tfir_pkg::CFG_IDX_BITS;
    localparam int PROD_W = SAMPLE_BITS + CW;

    logic [OW-1:0]           order_reg;
    logic [OW-1:0]           order_eff;
    logic signed [CW-1:0]    coef_reg [MAX_ORDER+1];

    logic                    p_valid_reg;
    logic                    p_frame_reg;
    logic signed [PROD_W-1:0] prod0_reg;
    logic                    a_valid_reg;
    logic                    a_frame_reg;
    logic signed [AW-1:0]    acc_reg;
    logic signed [AW-1:0]    acc_next;

    logic                    out_ready;
    logic                    a_adv;
    logic                    p_adv;
    logic                    load_en;
    logic                    upd_en;

    logic signed [AW-1:0]    sums   [MAX_ORDER];
    logic signed [AW-1:0]    sum_in [MAX_ORDER];
    tfir_pkg::cell_ctrl_t    ctrl   [MAX_ORDER];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= '0;
        end else if (cfg_valid && cfg_index == tfir_pkg::REG_FILTER_ORDER) begin
            order_reg <= cfg_data[OW-1:0];
        end
    end

    for (genvar j = 0; j <= MAX_ORDER; j++) begin : g_coef
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                coef_reg[j] <= '0;
            end else if (cfg_valid && cfg_index == tfir_pkg::REG_COEF_BASE + IW'(j)) begin
                coef_reg[j] <= cfg_data[CW-1:0];
            end
        end
    end

    assign order_eff = (order_reg > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : order_reg;

    assign a_adv   = !a_valid_reg || out_ready;
    assign p_adv   = !p_valid_reg || a_adv;
    assign s_ready = p_adv;
    assign load_en = s_valid && s_ready;
    assign upd_en  = p_valid_reg && a_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
        end else begin
            if (p_adv) begin
                p_valid_reg <= s_valid;
            end
            if (a_adv) begin
                a_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            prod0_reg   <= coef_reg[0] * s_sample_in;
            p_frame_reg <= s_frame_end_in;
        end
    end

    assign acc_next = AW'(prod0_reg) + ((order_eff != '0) ? sums[0] : '0);

    always_ff @(posedge aclk) begin
        if (upd_en) begin
            acc_reg     <= acc_next;
            a_frame_reg <= p_frame_reg;
        end
    end

    for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
        if (i == MAX_ORDER - 1) begin : g_last
            assign sum_in[i] = '0;
        end else begin : g_mid
            assign sum_in[i] = sums[i+1];
        end

        assign ctrl[i].load   = load_en;
        assign ctrl[i].update = upd_en;
        assign ctrl[i].active = (order_eff > OW'(i));
        assign ctrl[i].tail   = (order_eff > OW'(i + 1));

        tfir_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl[i]),
            .coef    (coef_reg[i+1]),
            .sample  (s_sample_in),
            .sum_in  (sum_in[i]),
            .sum_out (sums[i])
        );
    end

    tfir_out #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (a_valid_reg),
        .in_ready        (out_ready),
        .acc             (acc_reg),
        .frame_end       (a_frame_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_out    (m_sample_out),
        .m_clipped       (m_clipped),
        .m_frame_end_out (m_frame_end_out)
    );

    a_clip_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clipped) |->
            (m_sample_out == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
             m_sample_out == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("clipped result not at a rail");

    a_order0_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_en && order_eff == '0) |=> (sums[0] == '0))
        else $error("partial sum kept at order zero");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        load_en |=> p_valid_reg)
        else $error("accepted beat lost in product stage");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !p_valid_reg |-> s_ready)
        else $error("input stalled with empty product stage");

endmodule

### verif/transposed_fir_filter_top_tb.sv
module transposed_fir_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TAPS    = tfir_pkg::MAX_ORDER_DEF + 1;
    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int BLOCK_ITEMS = 108;

    typedef logic signed [tfir_pkg::SAMPLE_BITS_DEF-1:0] sample_t;
    typedef logic signed [tfir_pkg::COEF_BITS-1:0]       coef_t;
    typedef logic signed [tfir_pkg::ACC_BITS-1:0]        acc_t;

    localparam sample_t S_MIN = {1'b1, {(tfir_pkg::SAMPLE_BITS_DEF-1){1'b0}}};
    localparam sample_t S_MAX = {1'b0, {(tfir_pkg::SAMPLE_BITS_DEF-1){1'b1}}};
    localparam coef_t   C_MIN = {1'b1, {(tfir_pkg::COEF_BITS-1){1'b0}}};
    localparam coef_t   C_MAX = {1'b0, {(tfir_pkg::COEF_BITS-1){1'b1}}};

    typedef struct {
        sample_t sample_out;
        logic    clipped;
        logic    frame_end;
    } fir_result_t;

    class fir_scoreboard;
        logic [tfir_pkg::ORDER_BITS-1:0] order_reg;
        coef_t                           taps [NUM_TAPS];
        acc_t                            sums [tfir_pkg::MAX_ORDER_DEF];
        fir_result_t                     pending_outputs [$];
        int                              mismatches;
        int                              checked;
        int                              accepted;
        int                              clip_count;

        function new();
            order_reg  = '0;
            foreach (taps[i]) taps[i] = '0;
            foreach (sums[i]) sums[i] = '0;
            mismatches = 0;
            checked    = 0;
            accepted   = 0;
            clip_count = 0;
        endfunction

        function void set_register(logic [tfir_pkg::CFG_IDX_BITS-1:0] idx,
                                   logic [tfir_pkg::CFG_DATA_BITS-1:0] data);
            int k;
            k = int'(idx) - int'(tfir_pkg::REG_COEF_BASE);
            if (idx == tfir_pkg::REG_FILTER_ORDER) begin
                order_reg = data[tfir_pkg::ORDER_BITS-1:0];
            end else if (k >= 0 && k < NUM_TAPS) begin
                taps[k] = data[tfir_pkg::COEF_BITS-1:0];
            end
        endfunction

        // one transposed-form step: output from s0, then shift partial sums down
        function void note_sample(sample_t x, logic frame_end);
            int                                 eff_order;
            acc_t                               prod;
            acc_t                               acc;
            acc_t                               nxt;
            logic signed [tfir_pkg::ACC_BITS:0] rounded;
            fir_result_t                        res;
            eff_order = (order_reg > tfir_pkg::MAX_ORDER_DEF) ?
                        tfir_pkg::MAX_ORDER_DEF : int'(order_reg);
            prod = taps[0] * x;
            acc  = (eff_order > 0) ? prod + sums[0] : prod;
            for (int i = 0; i < tfir_pkg::MAX_ORDER_DEF; i++) begin
                if (i < eff_order) begin
                    nxt     = (i + 1 < eff_order) ? sums[i + 1] : acc_t'(0);
                    prod    = taps[i + 1] * x;
                    sums[i] = prod + nxt;
                end else begin
                    sums[i] = '0;
                end
            end
            rounded = acc;
            rounded = rounded + (1 <<< (tfir_pkg::COEF_FRAC - 1));
            rounded = rounded >>> tfir_pkg::COEF_FRAC;
            res.clipped = 1'b0;
            if (rounded > S_MAX) begin
                rounded     = S_MAX;
                res.clipped = 1'b1;
            end else if (rounded < S_MIN) begin
                rounded     = S_MIN;
                res.clipped = 1'b1;
            end
            res.sample_out = rounded[tfir_pkg::SAMPLE_BITS_DEF-1:0];
            res.frame_end  = frame_end;
            if (res.clipped) clip_count++;
            accepted++;
            pending_outputs.push_back(res);
        endfunction

        task report_mismatch(string field, longint got, longint want);
            mismatches++;
            if (mismatches <= 100)
                $display("mismatch at result %0d: %s got %0d expected %0d",
                         checked, field, got, want);
        endtask

        task check_output(sample_t got_sample, logic got_clip, logic got_fe);
            fir_result_t want;
            if (pending_outputs.size() == 0) begin
                report_mismatch("beat with nothing pending, sample_out", got_sample, 0);
                return;
            end
            want = pending_outputs.pop_front();
            checked++;
            if (got_sample !== want.sample_out)
                report_mismatch("sample_out", got_sample, want.sample_out);
            if (got_clip !== want.clipped)
                report_mismatch("clipped", got_clip, want.clipped);
            if (got_fe !== want.frame_end)
                report_mismatch("frame_end_out", got_fe, want.frame_end);
        endtask
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [tfir_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [tfir_pkg::CFG_DATA_BITS-1:0] cfg_data;
    logic                               s_valid;
    logic                               s_ready;
    sample_t                            s_sample_in;
    logic                               s_frame_end_in;
    logic                               m_valid;
    logic                               m_ready;
    sample_t                            m_sample_out;
    logic                               m_clipped;
    logic                               m_frame_end_out;

    fir_scoreboard sb = new();
    coef_t         tap_set [NUM_TAPS];
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            hold_len       = 0;
    int            cycle_count    = 0;
    int            settings_used  = 0;

    transposed_fir_filter_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_in     (s_sample_in),
        .s_frame_end_in  (s_frame_end_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_out    (m_sample_out),
        .m_clipped       (m_clipped),
        .m_frame_end_out (m_frame_end_out)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
        if (aresetn && s_valid && s_ready) sb.note_sample(s_sample_in, s_frame_end_in);
        if (aresetn && m_valid && m_ready)
            sb.check_output(m_sample_out, m_clipped, m_frame_end_out);
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_len != 0) begin
            m_ready  <= 1'b0;
            hold_len <= hold_len - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_outputs.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return sample_t'(int'($urandom_range(0, 64)) - 32);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coef_t pick_coef();
        case ($urandom_range(0, 9))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return '0;
            3:       return coef_t'(int'($urandom_range(0, 512)) - 256);
            default: return coef_t'($urandom);
        endcase
    endfunction

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending_outputs.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // waits for the block to go idle, then writes the order and every tap
    task automatic program_filter(logic [tfir_pkg::ORDER_BITS-1:0] order);
        logic [tfir_pkg::CFG_DATA_BITS-1:0] order_word;
        drain_results();
        order_word                           = tfir_pkg::CFG_DATA_BITS'($urandom);
        order_word[tfir_pkg::ORDER_BITS-1:0] = order;
        cfg_valid <= 1'b1;
        cfg_index <= tfir_pkg::REG_FILTER_ORDER;
        cfg_data  <= order_word;
        do @(posedge aclk); while (!cfg_ready);
        for (int k = 0; k < NUM_TAPS; k++) begin
            cfg_index <= tfir_pkg::REG_COEF_BASE + tfir_pkg::CFG_IDX_BITS'(k);
            cfg_data  <= tfir_pkg::CFG_DATA_BITS'(tap_set[k]);
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    task automatic send_sample(sample_t x, logic frame_end);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_in    <= x;
        s_frame_end_in <= frame_end;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        logic [tfir_pkg::ORDER_BITS-1:0] order;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_sample_in    = '0;
        s_frame_end_in = 1'b0;
        m_ready        = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct  = 9;
        recv_stall_pct = 64;

        // registers at reset: everything filters to zero
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b1);
        send_sample('0, 1'b0);

        // order zero, single negative full-scale tap
        foreach (tap_set[i]) tap_set[i] = pick_coef();
        tap_set[0] = C_MIN;
        program_filter(3'd0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample('0, 1'b1);

        // rounding half up around the output LSB
        foreach (tap_set[i]) tap_set[i] = pick_coef();
        tap_set[0] = 16'sd1;
        tap_set[1] = 16'sh4000;
        program_filter(3'd1);
        send_sample(16'sd16384, 1'b0);
        send_sample(-16'sd16384, 1'b0);
        send_sample(16'sd16383, 1'b0);
        send_sample(-16'sd16385, 1'b0);
        send_sample('0, 1'b1);

        // full order, all taps at the negative extreme: sums pile up and clip
        foreach (tap_set[i]) tap_set[i] = C_MIN;
        program_filter(3'd6);
        repeat (4) send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b1);

        // order above the maximum, impulse walking through alternating taps
        foreach (tap_set[i]) tap_set[i] = (i % 2 == 0) ? C_MAX : C_MIN;
        program_filter(3'd7);
        send_sample(S_MAX, 1'b0);
        for (int n = 0; n < 6; n++) send_sample('0, n == 5);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 64 : 0;
            recv_stall_pct = (phase == 0) ? 64 : (phase == 1) ? 9 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                foreach (tap_set[i]) tap_set[i] = pick_coef();
                case (blk)
                    0:       order = (phase == 1) ? 3'd7 : 3'd6;
                    1:       order = 3'd0;
                    default: order = tfir_pkg::ORDER_BITS'($urandom_range(0, 7));
                endcase
                program_filter(order);
                if (phase == 2 && blk == 0) hold_len <= 300;
                for (int n = 0; n < BLOCK_ITEMS; n++)
                    send_sample(pick_sample(), $urandom_range(0, 7) == 0);
            end
        end

        drain_results();
        repeat (LATENCY + 5) @(posedge aclk);

        $display("%0d samples filtered over %0d coefficient/order settings",
                 sb.accepted, settings_used);
        $display("%0d results checked, %0d saturated, %0d mismatches",
                 sb.checked, sb.clip_count, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_outputs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
design/tfir_pkg.sv
design/tfir_cell.sv
design/tfir_out.sv
design/transposed_fir_filter_top.sv
verif/transposed_fir_filter_top_tb.sv
